### design/rcfp_pkg.sv
// Shared types, constants and helper functions for the serial frame parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package rcfp_pkg;

  localparam logic [7:0]  HDR1     = 8'h20;
  localparam logic [7:0]  HDR2     = 8'h40;
  localparam logic [4:0]  DATA_LEN = 5'd28;
  localparam logic [15:0] SUM_INIT = 16'hFFFF - 16'h0020 - 16'h0040;

  localparam logic [1:0] SW_UNKNOWN = 2'd0;
  localparam logic [1:0] SW_UP      = 2'd1;
  localparam logic [1:0] SW_MIDDLE  = 2'd2;
  localparam logic [1:0] SW_DOWN    = 2'd3;

  localparam logic [15:0] VAL_UP     = 16'd1000;
  localparam logic [15:0] VAL_MIDDLE = 16'd1500;
  localparam logic [15:0] VAL_DOWN   = 16'd2000;

  typedef struct packed {
    logic       sum_init;
    logic       store_byte;
    logic [4:0] byte_idx;
    logic       ld_ck_low;
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       ld_err;
    logic       ld_ch;
    logic [3:0] ch_idx;
    logic       ch_last;
  } cmd_t;

  typedef struct packed {
    logic sum_match;
    logic out_free;
  } status_t;

  function automatic logic [1:0] switch_code(input logic [15:0] v);
    logic [1:0] code;
    code = SW_UNKNOWN;
    if (v == VAL_UP) code = SW_UP;
    else if (v == VAL_MIDDLE) code = SW_MIDDLE;
    else if (v == VAL_DOWN) code = SW_DOWN;
    return code;
  endfunction

endpackage

### design/rcfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module rcfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 14
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rcfp_dp.sv
// Datapath of the frame parser: checksum accumulator, channel word store and
// result register. Depends on rcfp_pkg and rcfp_ram.
module rcfp_dp import rcfp_pkg::*; #(
  parameter int NUM_CHANNELS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic [1:0]  switch_position,
  output logic        checksum_error,
  output logic        last
);

  localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

  logic [15:0] sum_acc;
  logic [7:0]  checksum_low;
  logic [7:0]  lo_byte;
  logic [3:0]  wr_word;
  logic        ram_we;
  logic [15:0] ram_rdata;

  assign wr_word = cmd.byte_idx[4:1];
  assign ram_we  = cmd.store_byte && cmd.byte_idx[0] && (wr_word < 4'(NUM_CHANNELS));

  rcfp_ram #(
    .WIDTH(16),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_word[AW-1:0]),
    .wdata({rx_byte, lo_byte}),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign status.sum_match = ({rx_byte, checksum_low} == sum_acc);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc      <= 16'hFFFF;
      checksum_low <= 8'd0;
    end else begin
      if (cmd.sum_init) begin
        sum_acc <= SUM_INIT;
      end else if (cmd.store_byte) begin
        sum_acc <= sum_acc - {8'd0, rx_byte};
      end
      if (cmd.ld_ck_low) begin
        checksum_low <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte && !cmd.byte_idx[0]) begin
      lo_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_err || cmd.ld_ch) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_err) begin
      channel_index   <= 4'd0;
      channel_value   <= 16'd0;
      switch_position <= SW_UNKNOWN;
      checksum_error  <= 1'b1;
      last            <= 1'b1;
    end else if (cmd.ld_ch) begin
      channel_index   <= cmd.ch_idx;
      channel_value   <= ram_rdata;
      switch_position <= switch_code(ram_rdata);
      checksum_error  <= 1'b0;
      last            <= cmd.ch_last;
    end
  end

endmodule

### design/rcfp_ctrl.sv
// Controller of the frame parser: header hunt, byte counting and the
// sequencer that reads out channel words. Depends on rcfp_pkg.
module rcfp_ctrl import rcfp_pkg::*; #(
  parameter int NUM_CHANNELS = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_HDR2 = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_CK1  = 3'd3;
  localparam logic [2:0] ST_CK2  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_LD   = 3'd6;

  localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

  logic [2:0] state, state_next;
  logic [4:0] byte_cnt, byte_cnt_next;
  logic [3:0] ch_cnt, ch_cnt_next;
  logic       take;

  always_comb begin
    in_stall = (state == ST_RD) || (state == ST_LD) ||
               ((state == ST_CK2) && !status.out_free);
    take = in_valid && !in_stall;
  end

  always_comb begin
    state_next    = state;
    byte_cnt_next = byte_cnt;
    ch_cnt_next   = ch_cnt;
    cmd           = '0;
    cmd.byte_idx  = byte_cnt;
    cmd.rd_addr   = ch_cnt;
    cmd.ch_idx    = ch_cnt;
    cmd.ch_last   = (ch_cnt == LAST_CH);
    case (state)
      ST_HDR2: begin
        if (take) begin
          if (rx_byte == HDR2) begin
            state_next    = ST_DATA;
            byte_cnt_next = 5'd0;
            cmd.sum_init  = 1'b1;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (take) begin
          cmd.store_byte = 1'b1;
          byte_cnt_next  = byte_cnt + 5'd1;
          if (byte_cnt == DATA_LEN - 5'd1) begin
            state_next = ST_CK1;
          end
        end
      end
      ST_CK1: begin
        if (take) begin
          cmd.ld_ck_low = 1'b1;
          state_next    = ST_CK2;
        end
      end
      ST_CK2: begin
        if (take) begin
          if (status.sum_match) begin
            ch_cnt_next = 4'd0;
            state_next  = ST_RD;
          end else begin
            cmd.ld_err = 1'b1;
            state_next = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (status.out_free) begin
          cmd.ld_ch = 1'b1;
          if (ch_cnt == LAST_CH) begin
            state_next = ST_HUNT;
          end else begin
            ch_cnt_next = ch_cnt + 4'd1;
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        if (take) begin
          state_next = (rx_byte == HDR1) ? ST_HDR2 : ST_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_HUNT;
      byte_cnt <= 5'd0;
      ch_cnt   <= 4'd0;
    end else begin
      state    <= state_next;
      byte_cnt <= byte_cnt_next;
      ch_cnt   <= ch_cnt_next;
    end
  end

endmodule

### design/rc_serial_frame_parser_unit.sv
// Serial frame parser top level: one received byte is taken per cycle while parsing, but the
// last checksum byte waits while out_stall holds the result register. After that byte of a
// good frame, NUM_CHANNELS results follow, each by a RAM read and then a result register load;
// input is held off until the last. A checksum mismatch gives one error result in the cycle after that byte.
// Synchronous active-high reset returns the parser to the header hunt and empties
// the result register; the channel word RAM is not cleared. Depends on rcfp_pkg.
module rc_serial_frame_parser_unit import rcfp_pkg::*; #(
  parameter int NUM_CHANNELS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic [1:0]  switch_position,
  output logic        checksum_error,
  output logic        last
);

  cmd_t    cmd;
  status_t status;

  rcfp_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .rx_byte (rx_byte),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  rcfp_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .switch_position(switch_position),
    .checksum_error (checksum_error),
    .last           (last)
  );

`ifndef SYNTH
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_error |-> last && (channel_index == 4'd0))
    else $error("Error item is not a single last item.");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_error && last |-> channel_index == 4'(NUM_CHANNELS - 1))
    else $error("Last flag on a channel other than the final one.");

  a_readout_stalls_input: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> in_stall)
    else $error("Input taken during channel readout.");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_ch |-> $past(cmd.rd_en) || $past(cmd.ld_ch == 1'b0 && in_stall))
    else $error("Channel load without a preceding RAM read.");
`endif

endmodule

### tb/sv/rc_serial_frame_parser_unit_tb.sv
// Testbench for the serial frame parser: feeds byte streams and checks every channel result.
// A scoreboard class predicts the results from the accepted bytes.
// Depends on rcfp_pkg and rc_serial_frame_parser_unit.
typedef enum logic [2:0] {
  PH_HUNT,
  PH_HDR2,
  PH_DATA,
  PH_CK_LOW,
  PH_CK_HIGH
} frame_phase_e;

typedef struct packed {
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic [1:0]  switch_position;
  logic        checksum_error;
  logic        last;
} channel_result_t;

class channel_frame_scoreboard;
  frame_phase_e    phase;
  logic [4:0]      bytes_left;
  logic [15:0]     sum_left;
  logic [7:0]      ck_low;
  logic [7:0]      data_bytes [28];
  channel_result_t expected_channels [$];
  int              num_channels;
  int              failures;

  function new(int n);
    num_channels = n;
    phase = PH_HUNT;
    bytes_left = 5'd0;
    sum_left = 16'hFFFF;
    ck_low = 8'h00;
    failures = 0;
  endfunction

  function int pending();
    return expected_channels.size();
  endfunction

  function void queue_expected(channel_result_t r);
    expected_channels.insert(expected_channels.size(), r);
  endfunction

  function channel_result_t take_oldest();
    channel_result_t r;
    r = expected_channels[0];
    expected_channels.delete(0);
    return r;
  endfunction

  function logic [1:0] decode_switch(logic [15:0] v);
    case (v)
      rcfp_pkg::VAL_UP:     return rcfp_pkg::SW_UP;
      rcfp_pkg::VAL_MIDDLE: return rcfp_pkg::SW_MIDDLE;
      rcfp_pkg::VAL_DOWN:   return rcfp_pkg::SW_DOWN;
      default:              return rcfp_pkg::SW_UNKNOWN;
    endcase
  endfunction

  function void take_byte(logic [7:0] b);
    channel_result_t r;
    logic [15:0] rx_sum;
    case (phase)
      PH_HDR2: begin
        if (b == rcfp_pkg::HDR2) begin
          phase = PH_DATA;
          bytes_left = rcfp_pkg::DATA_LEN;
          sum_left = 16'hFFFF - {8'h00, rcfp_pkg::HDR1} - {8'h00, rcfp_pkg::HDR2};
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (bytes_left != 5'd0) begin
          data_bytes[rcfp_pkg::DATA_LEN - bytes_left] = b;
          sum_left = sum_left - {8'h00, b};
          bytes_left = bytes_left - 5'd1;
          if (bytes_left == 5'd0) phase = PH_CK_LOW;
        end else begin
          phase = PH_CK_LOW;
        end
      end
      PH_CK_LOW: begin
        ck_low = b;
        phase = PH_CK_HIGH;
      end
      PH_CK_HIGH: begin
        phase = PH_HUNT;
        rx_sum = {b, ck_low};
        if (rx_sum != sum_left) begin
          r = '0;
          r.checksum_error = 1'b1;
          r.last = 1'b1;
          queue_expected(r);
        end else begin
          for (int k = 0; k < num_channels; k++) begin
            r.channel_index = 4'(k);
            r.channel_value = {data_bytes[2 * k + 1], data_bytes[2 * k]};
            r.switch_position = decode_switch(r.channel_value);
            r.checksum_error = 1'b0;
            r.last = (k == num_channels - 1);
            queue_expected(r);
          end
        end
      end
      default: phase = (b == rcfp_pkg::HDR1) ? PH_HDR2 : PH_HUNT;
    endcase
  endfunction

  function void compare_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  function void match_result(channel_result_t got);
    channel_result_t want;
    if (expected_channels.size() == 0) begin
      $error("result with nothing expected: channel_index %0d channel_value %0d",
             got.channel_index, got.channel_value);
      failures++;
      return;
    end
    want = take_oldest();
    compare_field("channel_index", want.channel_index, got.channel_index);
    compare_field("channel_value", want.channel_value, got.channel_value);
    compare_field("switch_position", want.switch_position, got.switch_position);
    compare_field("checksum_error", want.checksum_error, got.checksum_error);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module rc_serial_frame_parser_unit_tb;
  localparam int NUM_CHANNELS       = 14;
  localparam int RANDOM_FRAME_BYTES = 112;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int HOLD_AT_RESULT     = 5;
  localparam int HOLD_CYCLES        = 300;
  localparam int DRAIN_CYCLES       = 40;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic [1:0]  switch_position;
  logic        checksum_error;
  logic        last;

  channel_frame_scoreboard frame_sb;
  logic [15:0] chan_vals [NUM_CHANNELS];
  bit          in_burst = 1'b0;
  int          idle_cycles;

  rc_serial_frame_parser_unit #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .switch_position(switch_position),
    .checksum_error(checksum_error),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_sb.take_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] ck_flip);
    logic [15:0] ck;
    ck = 16'hFFFF - {8'h00, rcfp_pkg::HDR1} - {8'h00, rcfp_pkg::HDR2};
    send_byte(rcfp_pkg::HDR1);
    send_byte(rcfp_pkg::HDR2);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      send_byte(chan_vals[k][7:0]);
      send_byte(chan_vals[k][15:8]);
      ck = ck - {8'h00, chan_vals[k][7:0]} - {8'h00, chan_vals[k][15:8]};
    end
    ck = ck ^ ck_flip;
    send_byte(ck[7:0]);
    send_byte(ck[15:8]);
  endtask

  function automatic logic [15:0] pick_channel_value();
    case ($urandom_range(0, 9))
      0: return rcfp_pkg::VAL_UP;
      1: return rcfp_pkg::VAL_MIDDLE;
      2: return rcfp_pkg::VAL_DOWN;
      3: return rcfp_pkg::VAL_MIDDLE + 16'($urandom_range(0, 2)) - 16'd1;
      4: return 16'h0000;
      5: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic fill_random_channels();
    for (int k = 0; k < NUM_CHANNELS; k++) chan_vals[k] = pick_channel_value();
  endtask

  task automatic wait_results_drained();
    while (frame_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int random_bytes;
    logic [7:0] b;
    frame_sb = new(NUM_CHANNELS);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Noise in the hunt, then a bad second header that is itself a first header byte, then one more bad second header.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(rcfp_pkg::HDR2);
    send_byte(rcfp_pkg::HDR1);
    send_byte(rcfp_pkg::HDR1);
    send_byte(rcfp_pkg::HDR2);
    send_byte(rcfp_pkg::HDR1);
    send_byte(8'h41);
    chan_vals = '{16'd1000, 16'd1500, 16'd2000, 16'd0, 16'hFFFF, 16'd999, 16'd1001,
                  16'd1499, 16'd1501, 16'd1999, 16'd2001, 16'h00FF, 16'hFF00, 16'h5AA5};
    send_frame(16'h0000);
    send_frame(16'h0100);
    send_frame(16'h0001);

    in_valid <= 1'b0;
    wait_results_drained();

    random_bytes = 0;
    while (random_bytes < RANDOM_FRAME_BYTES) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        1: begin
          b = 8'($urandom_range(0, 255));
          if (b == rcfp_pkg::HDR2) b = ~b;
          send_byte(rcfp_pkg::HDR1);
          send_byte(b);
        end
        2: begin
          fill_random_channels();
          send_frame(16'($urandom_range(1, 65535)));
          random_bytes += 32;
        end
        default: begin
          fill_random_channels();
          send_frame(16'h0000);
          random_bytes += 32;
        end
      endcase
    end

    in_valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_sb.pending() != 0) begin
      $error("%0d expected results never arrived", frame_sb.pending());
      frame_sb.failures++;
    end
    if (frame_sb.failures == 0) begin
      $display("[rc_serial_frame_parser_unit] OK");
    end else begin
      $display("[rc_serial_frame_parser_unit] ERROR");
    end
    $finish;
  end

  initial begin
    int results_seen;
    int gap;
    bit out_burst;
    channel_result_t got;
    results_seen = 0;
    out_burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      else gap = out_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.channel_index = channel_index;
      got.channel_value = channel_value;
      got.switch_position = switch_position;
      got.checksum_error = checksum_error;
      got.last = last;
      frame_sb.match_result(got);
      results_seen++;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[rc_serial_frame_parser_unit] ERROR");
    $finish;
  end
endmodule
